// File: src/crt_pkg.sv
package crt_pkg;

   localparam int MAX_RANGES_DEF = 16;
   localparam int ADDR_BITS_DEF  = 48;

   localparam int ADDR_W     = 48;
   localparam int BYTES_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERLAP  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      ACT_REGISTER = 1'b0,
      ACT_FIND     = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

endpackage

// File: src/code_range_table_top.sv
// Channel   Ports                                            Handshake
// --------  -----------------------------------------------  ----------------------------
// request   req_action, req_range_start, req_range_bytes,    taken when start && !busy
//           req_query_address
// response  rsp_status, rsp_error_address, rsp_found,        one cycle, marked by
//           rsp_slot_index, rsp_hit_start, rsp_hit_bytes     rsp_strobe
//
// One item at a time; busy is high from the accepting edge until the result has gone out.
// The slot store is read one entry per cycle by a single compare unit behind a registered
// memory read. A scan reads every slot in turn unless a find hit or an overlap stops it;
// a register request with a bad argument skips the scan and goes straight to the result.
// Reset empties the table at once (valid bits), no clearing pass.
// rsp_strobe is not held off: a result is gone after its one cycle.
module code_range_table_top #(
   parameter int MAX_RANGES = crt_pkg::MAX_RANGES_DEF,
   parameter int ADDR_BITS  = crt_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [crt_pkg::ADDR_W-1:0]        req_range_start,
   input  logic [crt_pkg::BYTES_W-1:0]       req_range_bytes,
   input  logic [crt_pkg::ADDR_W-1:0]        req_query_address,
   output logic                              rsp_strobe,
   output logic [crt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [crt_pkg::ADDR_W-1:0]        rsp_error_address,
   output logic                              rsp_found,
   output logic [crt_pkg::SLOT_OUT_W-1:0]    rsp_slot_index,
   output logic [crt_pkg::ADDR_W-1:0]        rsp_hit_start,
   output logic [crt_pkg::BYTES_W-1:0]       rsp_hit_bytes
);

   localparam int AW     = crt_pkg::ADDR_W;
   localparam int BW     = crt_pkg::BYTES_W;
   localparam int OW     = crt_pkg::SLOT_OUT_W;
   localparam int SA_W   = (ADDR_BITS < AW) ? ADDR_BITS : AW;
   localparam int EA_W   = SA_W + 1;
   localparam int SLOT_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W  = $clog2(MAX_RANGES + 1);

   crt_pkg::state_type  state_ff, state_in;
   crt_pkg::action_type act_ff, act_in;
   crt_pkg::status_type status_ff, status_in;

   logic [SA_W-1:0]       key_ff, key_in;
   logic [BW-1:0]         bytes_ff, bytes_in;
   logic [EA_W-1:0]       end_ff, end_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                  free_found_ff, free_found_in;
   logic [SLOT_W-1:0]     free_idx_ff, free_idx_in;
   logic [MAX_RANGES-1:0] valid_ff, valid_in;

   logic [AW-1:0]         err_ff, err_in;
   logic                  found_ff, found_in;
   logic [OW-1:0]         slot_ff, slot_in;
   logic [AW-1:0]         hstart_ff, hstart_in;
   logic [BW-1:0]         hbytes_ff, hbytes_in;

   logic [SA_W-1:0]       mem_start [MAX_RANGES];
   logic [BW-1:0]         mem_bytes [MAX_RANGES];
   logic [EA_W-1:0]       mem_end   [MAX_RANGES];
   logic [SA_W-1:0]       rd_start_ff;
   logic [BW-1:0]         rd_bytes_ff;
   logic [EA_W-1:0]       rd_end_ff;

   logic              accept;
   logic              reg_err;
   logic              bad_size;
   logic              scan_end;
   logic              live;
   logic              rd_valid;
   logic              ovl;
   logic              hit;
   logic              scan_hit;
   logic              scan_last;
   logic              free_now;
   logic              have_free;
   logic [SLOT_W-1:0] fidx;
   logic              wr_en;
   logic              scan_more;

   // per-slot compare unit
   always_comb begin
      live      = (state_ff == crt_pkg::S_SCAN) && rd_vld_ff;
      rd_valid  = valid_ff[rd_idx_ff];
      ovl       = ({1'b0, key_ff} < rd_end_ff) && (EA_W'(rd_start_ff) < end_ff);
      hit       = (key_ff >= rd_start_ff) && ({1'b0, key_ff} < rd_end_ff);
      scan_hit  = live && rd_valid && ((act_ff == crt_pkg::ACT_FIND) ? hit : ovl);
      scan_last = live && (rd_idx_ff == SLOT_W'(MAX_RANGES - 1));
      free_now  = live && !rd_valid;
      have_free = free_found_ff || free_now;
      fidx      = free_found_ff ? free_idx_ff : rd_idx_ff;
      scan_more = cnt_ff < CNT_W'(MAX_RANGES);
      bad_size  = (req_range_bytes == '0) || (req_range_bytes[1:0] != 2'b00);
      reg_err   = (req_action == crt_pkg::ACT_REGISTER) &&
                  (bad_size || (req_range_start[1:0] != 2'b00));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         crt_pkg::S_IDLE: begin
            if (start) begin
               state_in = reg_err ? crt_pkg::S_RESP : crt_pkg::S_SCAN;
            end
         end
         crt_pkg::S_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = crt_pkg::S_RESP;
            end
         end
         crt_pkg::S_RESP: state_in = crt_pkg::S_IDLE;
         default:         state_in = crt_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      accept     = 1'b0;
      scan_end   = 1'b0;
      unique case (state_ff)
         crt_pkg::S_IDLE: begin
            busy   = 1'b0;
            accept = start;
         end
         crt_pkg::S_SCAN: scan_end = scan_hit || scan_last;
         crt_pkg::S_RESP: rsp_strobe = 1'b1;
         default:         busy = 1'b1;
      endcase
      wr_en = scan_end && (act_ff == crt_pkg::ACT_REGISTER) && !scan_hit && have_free;
   end

   always_comb begin
      act_in        = act_ff;
      key_in        = key_ff;
      bytes_in      = bytes_ff;
      end_in        = end_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = rd_vld_ff;
      rd_idx_in     = rd_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      status_in     = status_ff;
      err_in        = err_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      hstart_in     = hstart_ff;
      hbytes_in     = hbytes_ff;

      if (accept) begin
         act_in        = crt_pkg::action_type'(req_action);
         key_in        = (req_action == crt_pkg::ACT_FIND) ?
                         req_query_address[SA_W-1:0] : req_range_start[SA_W-1:0];
         bytes_in      = req_range_bytes;
         end_in        = EA_W'(req_range_start[SA_W-1:0]) + EA_W'(req_range_bytes);
         cnt_in        = '0;
         rd_vld_in     = 1'b0;
         free_found_in = 1'b0;
         status_in     = crt_pkg::ST_INVALID;
         err_in        = bad_size ? '0 : AW'(req_range_start[SA_W-1:0]);
         found_in      = 1'b0;
         slot_in       = '0;
         hstart_in     = '0;
         hbytes_in     = '0;
      end

      if (state_ff == crt_pkg::S_SCAN) begin
         cnt_in    = scan_more ? cnt_ff + CNT_W'(1) : cnt_ff;
         rd_vld_in = scan_more;
         rd_idx_in = cnt_ff[SLOT_W-1:0];
         if (free_now && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      if (scan_end) begin
         status_in = crt_pkg::ST_OK;
         err_in    = '0;
         found_in  = 1'b0;
         slot_in   = '0;
         hstart_in = '0;
         hbytes_in = '0;
         if (act_ff == crt_pkg::ACT_FIND) begin
            if (scan_hit) begin
               found_in  = 1'b1;
               slot_in   = OW'(rd_idx_ff);
               hstart_in = AW'(rd_start_ff);
               hbytes_in = rd_bytes_ff;
            end
         end else if (scan_hit) begin
            status_in = crt_pkg::ST_OVERLAP;
            err_in    = AW'(key_ff);
         end else if (have_free) begin
            slot_in        = OW'(fidx);
            valid_in[fidx] = 1'b1;
         end else begin
            status_in = crt_pkg::ST_FULL;
            err_in    = AW'(key_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= crt_pkg::S_IDLE;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         free_found_ff <= free_found_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      bytes_ff    <= bytes_in;
      end_ff      <= end_in;
      rd_idx_ff   <= rd_idx_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      err_ff      <= err_in;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      hstart_ff   <= hstart_in;
      hbytes_ff   <= hbytes_in;
   end

   // slot store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[fidx] <= key_ff;
         mem_bytes[fidx] <= bytes_ff;
         mem_end[fidx]   <= end_ff;
      end
      rd_start_ff <= mem_start[cnt_ff[SLOT_W-1:0]];
      rd_bytes_ff <= mem_bytes[cnt_ff[SLOT_W-1:0]];
      rd_end_ff   <= mem_end[cnt_ff[SLOT_W-1:0]];
   end

   assign rsp_status        = status_ff;
   assign rsp_error_address = err_ff;
   assign rsp_found         = found_ff;
   assign rsp_slot_index    = slot_ff;
   assign rsp_hit_start     = hstart_ff;
   assign rsp_hit_bytes     = hbytes_ff;

endmodule

// File: src/crt_checker.sv
module crt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_strobe,
   input logic [crt_pkg::STATUS_W-1:0]   rsp_status,
   input logic [crt_pkg::ADDR_W-1:0]     rsp_error_address,
   input logic                           rsp_found,
   input logic [crt_pkg::SLOT_OUT_W-1:0] rsp_slot_index
);

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a busy period");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_strobe_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("block still busy after its result");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |-> rsp_status == crt_pkg::ST_OK && rsp_error_address == '0)
      else $error("find hit with error fields set");

   a_err_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != crt_pkg::ST_OK |-> !rsp_found && rsp_slot_index == '0)
      else $error("error result carries a slot");

endmodule

bind code_range_table_top crt_checker u_crt_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_error_address (rsp_error_address),
   .rsp_found         (rsp_found),
   .rsp_slot_index    (rsp_slot_index)
);
